FILE: hw/rtl/bqf_pkg.sv
`default_nettype none

package bqf_pkg;

    // Coefficient register map
    localparam int NUM_COEFS = 5;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A2 = 3'd4;

    // Microprogram size
    localparam int STEP_W  = 3;
    localparam int N_STEPS = 8;

    typedef enum logic [2:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } t_coef_sel;

    // multiplier sample operand
    typedef enum logic [1:0] {
        MOP_IN = 2'd0,  // straight from the input port, also latches x
        MOP_X  = 2'd1,
        MOP_Y  = 2'd2
    } t_mop;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,    // acc = p + addend
        ACC_SUB  = 2'd2     // acc = acc - p
    } t_acc_op;

    typedef enum logic [1:0] {
        ADD_ZERO = 2'd0,
        ADD_D1   = 2'd1,
        ADD_D2   = 2'd2
    } t_add_sel;

    typedef enum logic [1:0] {
        BR_NEXT     = 2'd0,
        BR_WAIT_IN  = 2'd1, // hold until a request is taken
        BR_WAIT_OUT = 2'd2  // hold until output slot is free, then back to step 0
    } t_branch;

    typedef struct packed {
        t_coef_sel coef;
        t_mop      mop;
        t_acc_op   acc;
        t_add_sel  add;
        logic      wr_y;
        logic      wr_d1;
        logic      wr_d2;
        t_branch   br;
    } t_ctrl;

    // Microcode ROM.
    // y  = sat(b0*x + d1)
    // d1 = sat(b1*x + d2 - a1*y)
    // d2 = sat(b2*x - a2*y)
    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl c;
        c = '{coef: COEF_B0, mop: MOP_X, acc: ACC_HOLD, add: ADD_ZERO,
              wr_y: 1'b0, wr_d1: 1'b0, wr_d2: 1'b0, br: BR_NEXT};
        case (step)
            3'd0: begin
                c.coef = COEF_B0; c.mop = MOP_IN; c.br = BR_WAIT_IN;
            end
            3'd1: begin
                c.coef = COEF_B1; c.acc = ACC_LOAD; c.add = ADD_D1;
            end
            3'd2: begin
                c.acc = ACC_LOAD; c.add = ADD_D2; c.wr_y = 1'b1;
            end
            3'd3: begin
                c.coef = COEF_A1; c.mop = MOP_Y;
            end
            3'd4: begin
                c.coef = COEF_B2; c.acc = ACC_SUB;
            end
            3'd5: begin
                c.coef = COEF_A2; c.mop = MOP_Y; c.acc = ACC_LOAD;
                c.add = ADD_ZERO; c.wr_d1 = 1'b1;
            end
            3'd6: begin
                c.acc = ACC_SUB;
            end
            default: begin
                c.wr_d2 = 1'b1; c.br = BR_WAIT_OUT;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/biquad_tdf2_filter.sv
// Each taken request runs the microprogram on the single shared multiplier
//   and accumulator; a new sample is accepted only once the program is back
//   at its wait step and the last result has moved to the output slot.
// Reset (synchronous, active low) clears both delay terms, sets b0 to 1.0 and
//   the other coefficients to 0, and returns the sequencer to its wait step.
`default_nettype none

module biquad_tdf2_filter
    import bqf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input sample stream
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [SAMPLE_WIDTH-1:0] sample_in, zero fill above
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // filtered sample stream
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // [SAMPLE_WIDTH-1:0] sample_out, zero fill above
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  o_m_axis_tdata,
    // coefficient write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [COEF_WIDTH-1:0]         i_cfg_data
);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    // Coefficient bank, Q2.29 at the default width
    logic [NUM_COEFS-1:0][COEF_WIDTH-1:0] r_coef;

    // Sequencer
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             w_ctrl;

    // Output register
    logic                            r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0]  r_out_data;

    logic                            w_in_take;
    logic                            w_out_free;
    logic signed [SAMPLE_WIDTH-1:0]  w_y;

    assign w_ctrl = ucode(r_step);

    // A request is taken only in the wait step; the output register is a
    // separate slot, so the next sample can enter while a result is pending.
    assign o_s_axis_tready = (w_ctrl.br == BR_WAIT_IN);
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    always_comb begin
        unique case (w_ctrl.br)
            BR_NEXT:     n_step = r_step + 1'b1;
            BR_WAIT_IN:  n_step = w_in_take ? r_step + 1'b1 : r_step;
            BR_WAIT_OUT: n_step = w_out_free ? '0 : r_step;
            default:     n_step = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

    // Coefficient writes; indexes past the bank are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[CFG_B0] <= COEF_WIDTH'(1) << (COEF_WIDTH - 3);
            r_coef[CFG_B1] <= '0;
            r_coef[CFG_B2] <= '0;
            r_coef[CFG_A1] <= '0;
            r_coef[CFG_A2] <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_B0:  r_coef[CFG_B0] <= i_cfg_data;
                CFG_B1:  r_coef[CFG_B1] <= i_cfg_data;
                CFG_B2:  r_coef[CFG_B2] <= i_cfg_data;
                CFG_A1:  r_coef[CFG_A1] <= i_cfg_data;
                CFG_A2:  r_coef[CFG_A2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bqf_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_sample (i_s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_coef   (r_coef),
        .o_y      (w_y)
    );

    // Last step hands y to the output slot once it is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.br == BR_WAIT_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.br == BR_WAIT_OUT && w_out_free) begin
            r_out_data <= w_y;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'($unsigned(r_out_data));

    // A taken request always starts the program at step one.
    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> (r_step == STEP_W'(1)))
        else $error("sequencer did not start after input request");

    // The sequencer never leaves the wait step without a request.
    a_wait_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == '0 && !i_s_axis_tvalid) |=> (r_step == '0))
        else $error("sequencer left wait step without a request");

    // A new result appears only from the final program step.
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_step) == STEP_W'(N_STEPS - 1)))
        else $error("output valid raised outside the final step");

endmodule

`default_nettype wire

FILE: hw/rtl/bqf_datapath.sv
`default_nettype none

module bqf_datapath
    import bqf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire t_ctrl                                 i_ctrl,
    input  wire logic signed [SAMPLE_WIDTH-1:0]        i_sample,
    input  wire logic [NUM_COEFS-1:0][COEF_WIDTH-1:0]  i_coef,
    output logic signed [SAMPLE_WIDTH-1:0]             o_y
);

    localparam int DW   = SAMPLE_WIDTH + COEF_WIDTH;  // delay / product width
    localparam int AW   = DW + 2;                     // room for a three-term sum
    localparam int FRAC = COEF_WIDTH - 3;             // output shift
    localparam int RW   = SAMPLE_WIDTH + 4;           // rounded value before clamp

    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [SAMPLE_WIDTH-1:0] r_y;
    logic signed [DW-1:0]           r_p;
    logic signed [AW-1:0]           r_acc;
    logic signed [DW-1:0]           r_d1;
    logic signed [DW-1:0]           r_d2;

    logic signed [COEF_WIDTH-1:0]   w_coef;
    logic signed [SAMPLE_WIDTH-1:0] w_mop;
    logic signed [DW-1:0]           w_prod;
    logic signed [DW-1:0]           w_add;
    logic signed [AW-1:0]           n_acc;
    logic signed [DW-1:0]           w_acc_sat;
    logic signed [SAMPLE_WIDTH+2:0] w_shift;
    logic signed [RW-1:0]           w_rnd;
    logic signed [SAMPLE_WIDTH-1:0] w_y;

    always_comb begin
        case (i_ctrl.coef)
            COEF_B0: w_coef = i_coef[CFG_B0];
            COEF_B1: w_coef = i_coef[CFG_B1];
            COEF_B2: w_coef = i_coef[CFG_B2];
            COEF_A1: w_coef = i_coef[CFG_A1];
            COEF_A2: w_coef = i_coef[CFG_A2];
            default: w_coef = '0;
        endcase
    end

    always_comb begin
        case (i_ctrl.mop)
            MOP_IN:  w_mop = i_sample;
            MOP_X:   w_mop = r_x;
            MOP_Y:   w_mop = r_y;
            default: w_mop = '0;
        endcase
    end

    // full-precision product, always exact in DW bits
    assign w_prod = DW'(w_coef) * DW'(w_mop);

    always_comb begin
        case (i_ctrl.add)
            ADD_D1:  w_add = r_d1;
            ADD_D2:  w_add = r_d2;
            default: w_add = '0;
        endcase
    end

    always_comb begin
        case (i_ctrl.acc)
            ACC_LOAD: n_acc = AW'(r_p) + AW'(w_add);
            ACC_SUB:  n_acc = r_acc - AW'(r_p);
            default:  n_acc = r_acc;
        endcase
    end

    // clamp accumulator to delay width
    always_comb begin
        if ((&r_acc[AW-1:DW-1]) || !(|r_acc[AW-1:DW-1])) begin
            w_acc_sat = r_acc[DW-1:0];
        end else if (r_acc[AW-1]) begin
            w_acc_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            w_acc_sat = {1'b0, {(DW-1){1'b1}}};
        end
    end

    // round half up, then clamp to sample width
    assign w_shift = w_acc_sat[DW-1:FRAC];
    assign w_rnd   = RW'(w_shift) + RW'({1'b0, w_acc_sat[FRAC-1]});

    always_comb begin
        if ((&w_rnd[RW-1:SAMPLE_WIDTH-1]) || !(|w_rnd[RW-1:SAMPLE_WIDTH-1])) begin
            w_y = w_rnd[SAMPLE_WIDTH-1:0];
        end else if (w_rnd[RW-1]) begin
            w_y = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            w_y = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p   <= w_prod;
        r_acc <= n_acc;
        if (i_ctrl.mop == MOP_IN) begin
            r_x <= i_sample;
        end
        if (i_ctrl.wr_y) begin
            r_y <= w_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else begin
            if (i_ctrl.wr_d1) begin
                r_d1 <= w_acc_sat;
            end
            if (i_ctrl.wr_d2) begin
                r_d2 <= w_acc_sat;
            end
        end
    end

    assign o_y = r_y;

endmodule

`default_nettype wire
